@@ design/fisr_pkg.sv @@
// ----------------------------------------------------------------------------
// fisr_pkg: shared constants and helpers for the inverse square root core
// Binary32 constants, register map and leading zero counters.
// ----------------------------------------------------------------------------
package fisr_pkg;

	localparam logic [31:0] MAGIC_GUESS     = 32'h5f3759df;
	localparam logic [31:0] CANON_NAN       = 32'h7FC00000;
	localparam logic [31:0] FP_ONE_HALF     = 32'h3F000000;
	localparam logic [31:0] FP_THREE_HALVES = 32'h3FC00000;

	// register index, taken from paddr[2]
	localparam logic REG_REFINE_STEPS = 1'b0;

	// leading zeros of a 48-bit product
	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] cnt;
		cnt = 6'd47;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) cnt = 6'(47 - i);
		end
		return cnt;
	endfunction

	// leading zeros of a 27-bit sum (27 when zero)
	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] cnt;
		cnt = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (v[i]) cnt = 5'(26 - i);
		end
		return cnt;
	endfunction

endpackage

@@ design/fisr_fmul.sv @@
// ----------------------------------------------------------------------------
// fisr_fmul: pipelined binary32 multiplier
// Three stages: multiply, normalize, round to nearest even and pack.
// ----------------------------------------------------------------------------
module fisr_fmul import fisr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        out_vld,
	output logic [31:0] y
);

	// stage 1: unpack, specials, mantissa product
	logic [7:0]  ea, eb, eae, ebe;
	logic [23:0] ma, mb;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic        nan_c, inf_c;

	assign ea  = a[30:23];
	assign eb  = b[30:23];
	assign eae = (ea == 8'd0) ? 8'd1 : ea;
	assign ebe = (eb == 8'd0) ? 8'd1 : eb;
	assign ma  = {ea != 8'd0, a[22:0]};
	assign mb  = {eb != 8'd0, b[22:0]};
	assign a_nan  = (ea == 8'hFF) && (a[22:0] != 23'd0);
	assign b_nan  = (eb == 8'hFF) && (b[22:0] != 23'd0);
	assign a_inf  = (ea == 8'hFF) && (a[22:0] == 23'd0);
	assign b_inf  = (eb == 8'hFF) && (b[22:0] == 23'd0);
	assign a_zero = (ea == 8'd0) && (a[22:0] == 23'd0);
	assign b_zero = (eb == 8'd0) && (b[22:0] == 23'd0);
	assign nan_c  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
	assign inf_c  = (a_inf || b_inf) && !nan_c;

	logic               vld_s1, nan_s1, inf_s1, zero_s1, sign_s1;
	logic [47:0]        prod_s1;
	logic signed [9:0]  exp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nan_s1  <= nan_c;
			inf_s1  <= inf_c;
			zero_s1 <= (a_zero || b_zero) && !nan_c && !inf_c;
			sign_s1 <= a[31] ^ b[31];
			prod_s1 <= ma * mb;
			exp_s1  <= $signed({2'b00, eae}) + $signed({2'b00, ebe}) - 10'sd126;
		end
	end

	// stage 2: left normalize
	logic [5:0]         lz;
	logic               vld_s2, nan_s2, inf_s2, zero_s2, sign_s2;
	logic [47:0]        norm_s2;
	logic signed [9:0]  exp_s2;

	assign lz = lzc48(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nan_s2  <= nan_s1;
			inf_s2  <= inf_s1;
			zero_s2 <= zero_s1;
			sign_s2 <= sign_s1;
			norm_s2 <= prod_s1 << lz;
			exp_s2  <= exp_s1 - $signed({4'b0000, lz});
		end
	end

	// stage 3: subnormal shift, rounding, packing
	logic [9:0]  sh;
	logic [6:0]  shc;
	logic [47:0] dn;
	logic        lost;
	logic [7:0]  field;
	logic        guard, sticky, rnd;
	logic [30:0] packed_mag;
	logic [31:0] res_c;

	always_comb begin
		sh   = 10'd1 - exp_s2;
		shc  = 7'd0;
		dn   = norm_s2;
		lost = 1'b0;
		field = exp_s2[7:0];
		if (exp_s2 <= 10'sd0) begin
			shc   = (sh >= 10'd48) ? 7'd48 : sh[6:0];
			dn    = norm_s2 >> shc;
			lost  = |(norm_s2 & ~({48{1'b1}} << shc));
			field = 8'd0;
		end
		guard      = dn[23];
		sticky     = (|dn[22:0]) || lost;
		rnd        = guard && (sticky || dn[24]);
		packed_mag = {field, dn[46:24]} + {30'd0, rnd};
		if (nan_s2) begin
			res_c = CANON_NAN;
		end else if (inf_s2 || (exp_s2 >= 10'sd255)) begin
			res_c = {sign_s2, 8'hFF, 23'd0};
		end else if (zero_s2) begin
			res_c = {sign_s2, 31'd0};
		end else begin
			res_c = {sign_s2, packed_mag};
		end
	end

	logic        vld_s3;
	logic [31:0] res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res_c;
		end
	end

	assign out_vld = vld_s3;
	assign y       = res_s3;

endmodule

@@ design/fisr_fadd.sv @@
// ----------------------------------------------------------------------------
// fisr_fadd: pipelined binary32 adder
// Three stages: align, add with leading zero count, normalize and round.
// ----------------------------------------------------------------------------
module fisr_fadd import fisr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        out_vld,
	output logic [31:0] y
);

	// stage 1: unpack, order by magnitude, align the smaller operand
	logic [7:0]  ea, eb;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, nan_c, inf_c;
	logic        swap;
	logic [31:0] big, sml;
	logic [7:0]  eb_eff, es_eff, d;
	logic [4:0]  shc;
	logic [26:0] sml27, al;

	assign ea     = a[30:23];
	assign eb     = b[30:23];
	assign a_nan  = (ea == 8'hFF) && (a[22:0] != 23'd0);
	assign b_nan  = (eb == 8'hFF) && (b[22:0] != 23'd0);
	assign a_inf  = (ea == 8'hFF) && (a[22:0] == 23'd0);
	assign b_inf  = (eb == 8'hFF) && (b[22:0] == 23'd0);
	assign a_zero = (ea == 8'd0) && (a[22:0] == 23'd0);
	assign b_zero = (eb == 8'd0) && (b[22:0] == 23'd0);
	assign nan_c  = a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]));
	assign inf_c  = (a_inf || b_inf) && !nan_c;

	always_comb begin
		swap   = b[30:0] > a[30:0];
		big    = swap ? b : a;
		sml    = swap ? a : b;
		eb_eff = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es_eff = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		d      = eb_eff - es_eff;
		shc    = (d >= 8'd27) ? 5'd27 : d[4:0];
		sml27  = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
		al     = sml27 >> shc;
		al[0]  = al[0] | (|(sml27 & ~({27{1'b1}} << shc)));
	end

	logic        vld_s1, nan_s1, inf_s1, isgn_s1, zz_s1, zsgn_s1, sub_s1, sign_s1;
	logic [26:0] big_s1, al_s1;
	logic [7:0]  exp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nan_s1  <= nan_c;
			inf_s1  <= inf_c;
			isgn_s1 <= a_inf ? a[31] : b[31];
			zz_s1   <= a_zero && b_zero;
			zsgn_s1 <= a[31] && b[31];
			sub_s1  <= a[31] ^ b[31];
			sign_s1 <= big[31];
			big_s1  <= {big[30:23] != 8'd0, big[22:0], 3'b000};
			al_s1   <= al;
			exp_s1  <= eb_eff;
		end
	end

	// stage 2: add or subtract, count leading zeros
	logic [27:0] sum_c;

	assign sum_c = sub_s1 ? ({1'b0, big_s1} - {1'b0, al_s1})
	                      : ({1'b0, big_s1} + {1'b0, al_s1});

	logic        vld_s2, nan_s2, inf_s2, isgn_s2, zz_s2, zsgn_s2, sign_s2;
	logic [27:0] sum_s2;
	logic [4:0]  lz_s2;
	logic [7:0]  exp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nan_s2  <= nan_s1;
			inf_s2  <= inf_s1;
			isgn_s2 <= isgn_s1;
			zz_s2   <= zz_s1;
			zsgn_s2 <= zsgn_s1;
			sign_s2 <= sign_s1;
			sum_s2  <= sum_c;
			lz_s2   <= lzc27(sum_c[26:0]);
			exp_s2  <= exp_s1;
		end
	end

	// stage 3: normalize, round to nearest even, pack
	logic [7:0]  emax, lzl;
	logic [26:0] n27;
	logic [8:0]  e3;
	logic [7:0]  field;
	logic        guard, sticky, rnd;
	logic [30:0] packed_mag;
	logic [31:0] res_c;

	always_comb begin
		emax = exp_s2 - 8'd1;
		lzl  = ({3'b000, lz_s2} > emax) ? emax : {3'b000, lz_s2};
		if (sum_s2[27]) begin
			n27    = sum_s2[27:1];
			n27[0] = sum_s2[1] | sum_s2[0];
			e3     = {1'b0, exp_s2} + 9'd1;
		end else begin
			n27 = sum_s2[26:0] << lzl;
			e3  = {1'b0, exp_s2} - {1'b0, lzl};
		end
		field      = n27[26] ? e3[7:0] : 8'd0;
		guard      = n27[2];
		sticky     = |n27[1:0];
		rnd        = guard && (sticky || n27[3]);
		packed_mag = {field, n27[25:3]} + {30'd0, rnd};
		if (nan_s2) begin
			res_c = CANON_NAN;
		end else if (inf_s2) begin
			res_c = {isgn_s2, 8'hFF, 23'd0};
		end else if (e3 >= 9'd255) begin
			res_c = {sign_s2, 8'hFF, 23'd0};
		end else if (sum_s2 == 28'd0) begin
			res_c = {zz_s2 && zsgn_s2, 31'd0};
		end else begin
			res_c = {sign_s2, packed_mag};
		end
	end

	logic        vld_s3;
	logic [31:0] res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res_c;
		end
	end

	assign out_vld = vld_s3;
	assign y       = res_s3;

endmodule

@@ design/fast_inverse_square_root_core.sv @@
// throughput: one operand per cycle while in_stall is low, a chain of nine 3-stage float units
// a stalled result beat lets one more beat into a skid register, then in_stall
// rises and the whole pipeline holds until the result side takes a beat
// reset clears all valid bits and sets refine_steps to one
// ----------------------------------------------------------------------------
// fast_inverse_square_root_core: pipelined approximate 1/sqrt(x)
// Bit-level guess followed by one or two Newton-Raphson refinements.
// ----------------------------------------------------------------------------
module fast_inverse_square_root_core import fisr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] operand_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_bits,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration register
	logic [1:0] refine_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refine_q <= 2'd1;
		end else if (psel && penable && pwrite && (paddr[2] == REG_REFINE_STEPS)) begin
			refine_q <= pwdata[1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_REFINE_STEPS) ? {30'd0, refine_q} : 32'd0;

	// global advance: whole pipeline holds while the skid entry is occupied
	logic en;
	logic skid_vld_q;
	assign en       = !skid_vld_q;
	assign in_stall = skid_vld_q;

	logic        acc;
	logic [31:0] half_bits, guess;
	assign acc       = in_valid && en;
	assign half_bits = {operand_bits[31], operand_bits[31:1]};
	assign guess     = MAGIC_GUESS - half_bits;

	// half of x, guess waits alongside
	logic        hx_vld;
	logic [31:0] hx;
	logic [31:0] g_q [3];

	fisr_fmul u_half (.clk, .arst_n, .en, .in_vld(acc), .a(operand_bits), .b(FP_ONE_HALF),
		.out_vld(hx_vld), .y(hx));

	always_ff @(posedge clk) begin
		if (en) begin
			g_q[0] <= guess;
			for (int i = 1; i < 3; i++) g_q[i] <= g_q[i-1];
		end
	end

	// first refinement
	logic        r1a_vld, r1b_vld, r1c_vld, y1_vld;
	logic [31:0] r1a, r1b, r1c, y1;
	logic [31:0] y0_q [9];
	logic [31:0] hx_q [12];

	always_ff @(posedge clk) begin
		if (en) begin
			y0_q[0] <= g_q[2];
			for (int i = 1; i < 9; i++) y0_q[i] <= y0_q[i-1];
			hx_q[0] <= hx;
			for (int i = 1; i < 12; i++) hx_q[i] <= hx_q[i-1];
		end
	end

	fisr_fmul u_r1a (.clk, .arst_n, .en, .in_vld(hx_vld), .a(hx), .b(g_q[2]),
		.out_vld(r1a_vld), .y(r1a));
	fisr_fmul u_r1b (.clk, .arst_n, .en, .in_vld(r1a_vld), .a(r1a), .b(y0_q[2]),
		.out_vld(r1b_vld), .y(r1b));
	fisr_fadd u_r1c (.clk, .arst_n, .en, .in_vld(r1b_vld), .a(FP_THREE_HALVES),
		.b({~r1b[31], r1b[30:0]}), .out_vld(r1c_vld), .y(r1c));
	fisr_fmul u_r1d (.clk, .arst_n, .en, .in_vld(r1c_vld), .a(y0_q[8]), .b(r1c),
		.out_vld(y1_vld), .y(y1));

	// second refinement
	logic        r2a_vld, r2b_vld, r2c_vld, y2_vld;
	logic [31:0] r2a, r2b, r2c, y2;
	logic [31:0] y1_q [12];

	always_ff @(posedge clk) begin
		if (en) begin
			y1_q[0] <= y1;
			for (int i = 1; i < 12; i++) y1_q[i] <= y1_q[i-1];
		end
	end

	fisr_fmul u_r2a (.clk, .arst_n, .en, .in_vld(y1_vld), .a(hx_q[11]), .b(y1),
		.out_vld(r2a_vld), .y(r2a));
	fisr_fmul u_r2b (.clk, .arst_n, .en, .in_vld(r2a_vld), .a(r2a), .b(y1_q[2]),
		.out_vld(r2b_vld), .y(r2b));
	fisr_fadd u_r2c (.clk, .arst_n, .en, .in_vld(r2b_vld), .a(FP_THREE_HALVES),
		.b({~r2b[31], r2b[30:0]}), .out_vld(r2c_vld), .y(r2c));
	fisr_fmul u_r2d (.clk, .arst_n, .en, .in_vld(r2c_vld), .a(y1_q[8]), .b(r2c),
		.out_vld(y2_vld), .y(y2));

	// pick the refinement depth, canonical nan
	logic [31:0] sel;
	logic [31:0] res_q;
	logic [31:0] skid_res_q;
	logic        vld_q;

	always_comb begin
		sel = refine_q[1] ? y2 : y1_q[11];
		if ((sel[30:23] == 8'hFF) && (sel[22:0] != 23'd0)) sel = CANON_NAN;
	end

	// output register, one skid entry behind a stalled result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!skid_vld_q) begin
			if (vld_q && out_stall) begin
				skid_vld_q <= y2_vld;
			end else begin
				vld_q <= y2_vld;
			end
		end else if (!out_stall) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			if (vld_q && out_stall) begin
				skid_res_q <= sel;
			end else begin
				res_q <= sel;
			end
		end else if (!out_stall) begin
			res_q <= skid_res_q;
		end
	end

	assign out_valid   = vld_q;
	assign result_bits = res_q;

endmodule

@@ design/fisr_checker.sv @@
// ----------------------------------------------------------------------------
// fisr_checker: port-level assertions for the inverse square root core
// Watches the handshakes and the result encoding on the top level ports.
// ----------------------------------------------------------------------------
module fisr_checker import fisr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] result_bits,
	input logic        pready
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_bits))
		else $error("stalled result beat changed");

	// input side only stalls behind a pending result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stall without a pending result beat");

	// any nan leaves in canonical form
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_bits[30:23] == 8'hFF) && (result_bits[22:0] != 23'd0)
		|-> result_bits == CANON_NAN)
		else $error("non-canonical nan on result");

	// register port never waits
	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind fast_inverse_square_root_core fisr_checker u_fisr_checker (
	.clk, .arst_n, .in_stall, .out_valid, .out_stall, .result_bits, .pready
);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for fast_inverse_square_root_core
// Drives binary32 operands through the valid/stall channel, predicts every
// result with a bit-exact binary32 model of the guess and Newton steps, and
// checks the result beats in order across several refine_steps settings.
// ----------------------------------------------------------------------------
module tb;
	import fisr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT  = 4000;
	localparam int DRAIN_WAIT  = 40;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] operand_bits;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] result_bits;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic [31:0] result_q[$];
	logic [1:0]  steps_cfg;
	int          err_cnt;
	int          in_idle_pct;
	int          out_idle_pct;
	int          quiet_cycles;
	bit          in_took;

	typedef struct {
		logic [31:0] operand;
		logic [31:0] result;
		bit          known;
	} vec_t;

	fast_inverse_square_root_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operand_bits (operand_bits),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_bits  (result_bits),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// round a positive magnitude mag * 2^ex to binary32, nearest even
	function automatic logic [31:0] fp_round(bit sgn, logic [79:0] mag, int ex);
		int          msb;
		int          bexp;
		int          sh;
		logic [79:0] wide;
		logic [24:0] sig;
		bit          guard;
		bit          sticky;
		msb = 0;
		for (int i = 0; i < 80; i++) begin
			if (mag[i]) msb = i;
		end
		bexp = msb + ex + 127;
		if (bexp < 1) begin
			sh = msb - 23 + (1 - bexp);
			bexp = 1;
		end else begin
			sh = msb - 23;
		end
		guard = 1'b0;
		sticky = 1'b0;
		if (sh <= 0) begin
			wide = mag << (-sh);
			sig = wide[24:0];
		end else if (sh > 80) begin
			sig = '0;
		end else begin
			wide = mag >> sh;
			sig = wide[24:0];
			guard = mag[sh-1];
			sticky = |(mag & ((80'd1 << (sh - 1)) - 80'd1));
		end
		if (guard && (sticky || sig[0])) sig = sig + 25'd1;
		if (sig[24]) begin
			sig = sig >> 1;
			bexp++;
		end
		if (bexp >= 255) return {sgn, 8'hFF, 23'd0};
		return {sgn, sig[23] ? 8'(bexp) : 8'd0, sig[22:0]};
	endfunction

	function automatic bit fp_is_nan(logic [31:0] v);
		return v[30:23] == 8'hFF && v[22:0] != 0;
	endfunction

	// binary32 product
	function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
		logic [23:0] ma;
		logic [23:0] mb;
		logic [47:0] prod;
		bit          sgn;
		sgn = a[31] ^ b[31];
		ma = {a[30:23] != 0, a[22:0]};
		mb = {b[30:23] != 0, b[22:0]};
		if (fp_is_nan(a) || fp_is_nan(b)) return CANON_NAN;
		if (a[30:23] == 8'hFF) return (b[30:0] == 0) ? CANON_NAN : {sgn, 8'hFF, 23'd0};
		if (b[30:23] == 8'hFF) return (a[30:0] == 0) ? CANON_NAN : {sgn, 8'hFF, 23'd0};
		if (ma == 0 || mb == 0) return {sgn, 31'd0};
		prod = ma * mb;
		return fp_round(sgn, 80'(prod),
			(a[30:23] == 0 ? 1 : int'(a[30:23])) + (b[30:23] == 0 ? 1 : int'(b[30:23])) - 300);
	endfunction

	// binary32 sum
	function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
		logic [31:0] tmp;
		logic [79:0] ma;
		logic [79:0] mb;
		logic [79:0] mag;
		int          ea;
		int          eb;
		int          d;
		int          ex;
		bit          sgn;
		if (fp_is_nan(a) || fp_is_nan(b)) return CANON_NAN;
		if (a[30:23] == 8'hFF && b[30:23] == 8'hFF && a[31] != b[31]) return CANON_NAN;
		if (a[30:23] == 8'hFF) return a;
		if (b[30:23] == 8'hFF) return b;
		if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
		if (a[30:0] == 0) return b;
		if (b[30:0] == 0) return a;
		ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
		eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
		if (ea < eb) begin
			tmp = a; a = b; b = tmp;
			d = ea; ea = eb; eb = d;
		end
		d = ea - eb;
		ma = 80'({a[30:23] != 0, a[22:0]});
		mb = 80'({b[30:23] != 0, b[22:0]});
		// far below the rounding point the smaller term only counts as sticky
		if (d > 40) begin
			ma = ma << 40;
			mb = 80'd1;
			ex = ea - 40 - 150;
		end else begin
			ma = ma << d;
			ex = eb - 150;
		end
		if (a[31] == b[31]) begin
			mag = ma + mb;
			sgn = a[31];
		end else if (ma > mb) begin
			mag = ma - mb;
			sgn = a[31];
		end else if (mb > ma) begin
			mag = mb - ma;
			sgn = b[31];
		end else begin
			return 32'd0;
		end
		return fp_round(sgn, mag, ex);
	endfunction

	// one Newton step y * (1.5 - ((x/2) * y) * y)
	function automatic logic [31:0] newton_step(logic [31:0] y, logic [31:0] hx);
		logic [31:0] t;
		t = fp_mul(hx, y);
		t = fp_mul(t, y);
		t = fp_add(FP_THREE_HALVES, t ^ 32'h80000000);
		return fp_mul(y, t);
	endfunction

	function automatic logic [31:0] rsqrt_predict(logic [31:0] x, logic [1:0] steps);
		logic [31:0] y;
		logic [31:0] hx;
		y = MAGIC_GUESS - ((x >> 1) | (x & 32'h80000000));
		hx = fp_mul(x, FP_ONE_HALF);
		y = newton_step(y, hx);
		if (steps >= 2'd2) y = newton_step(y, hx);
		if (fp_is_nan(y)) y = CANON_NAN;
		return y;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		err_cnt++;
	endtask

	// operand beat accept and result beat check
	always @(posedge clk) begin
		in_took = in_valid && !in_stall && arst_n;
		if (in_took) result_q.push_back(rsqrt_predict(operand_bits, steps_cfg));
		if (out_valid && !out_stall && arst_n) begin
			if (result_q.size() == 0) begin
				report("unexpected result beat", result_bits, 32'd0);
			end else if (result_bits !== result_q[0]) begin
				report("result_bits", result_bits, result_q[0]);
				void'(result_q.pop_front());
			end else begin
				void'(result_q.pop_front());
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < out_idle_pct);
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (in_took || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_operand(logic [31:0] op);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operand_bits <= op;
		do @(negedge clk); while (!in_took);
	endtask

	task automatic write_steps(logic [1:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {REG_REFINE_STEPS, 2'b00};
		pwdata <= 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		steps_cfg = val;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (result_q.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_operand();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(9))
			4, 5: v[30:23] = 8'($urandom_range(100, 160));
			6: v[30:23] = 8'd0;
			7: v[30:23] = 8'hFF;
			8: v[30:23] = $urandom_range(1) ? 8'd1 : 8'd254;
			9: begin
				v[31] = 1'b0;
				v[30:23] = 8'($urandom_range(200, 254));
			end
			default: ;
		endcase
		if ($urandom_range(19) == 0) v[22:0] = $urandom_range(1) ? 23'd0 : 23'h7FFFFF;
		return v;
	endfunction

	task automatic random_run(int count, int sender_pct, int receiver_pct);
		in_idle_pct = sender_pct;
		out_idle_pct = receiver_pct;
		for (int i = 0; i < count; i++) send_operand(rand_operand());
		drain();
	endtask

	// directed operands, known results typed where obvious
	vec_t directed[] = '{
		'{32'h3F800000, 32'h0, 1'b0},   // one
		'{32'h40800000, 32'h0, 1'b0},   // four
		'{32'h00000000, 32'h0, 1'b0},   // plus zero
		'{32'h80000000, 32'h0, 1'b0},   // minus zero
		'{32'h7F800000, 32'hFF800000, 1'b1},  // plus infinity
		'{32'hFF800000, 32'h0, 1'b0},   // minus infinity
		'{32'h7FC00000, CANON_NAN, 1'b1},     // quiet nan
		'{32'h7F800001, CANON_NAN, 1'b1},     // signaling nan
		'{32'hFFFFFFFF, CANON_NAN, 1'b1},     // negative nan, all ones
		'{32'h00000001, 32'h0, 1'b0},   // smallest subnormal
		'{32'h007FFFFF, 32'h0, 1'b0},   // largest subnormal
		'{32'h00800000, 32'h0, 1'b0},   // smallest normal
		'{32'h7F7FFFFF, 32'h0, 1'b0},   // largest normal
		'{32'hBF800000, 32'h0, 1'b0},   // minus one
		'{32'h80000001, 32'h0, 1'b0},   // negative subnormal
		'{32'h5F3759DF, 32'h0, 1'b0},   // the magic pattern itself
		'{32'h3E800000, 32'h0, 1'b0},   // quarter
		'{32'h55555555, 32'h0, 1'b0},
		'{32'hAAAAAAAA, 32'h0, 1'b0}
	};

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operand_bits = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		err_cnt = 0;
		quiet_cycles = 0;
		in_took = 1'b0;
		steps_cfg = 2'd1;
		in_idle_pct = 35;
		out_idle_pct = 57;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed beats at the reset setting
		foreach (directed[i]) begin
			send_operand(directed[i].operand);
			if (directed[i].known && rsqrt_predict(directed[i].operand, steps_cfg)
					!== directed[i].result)
				report("directed row", rsqrt_predict(directed[i].operand, steps_cfg),
					directed[i].result);
		end
		drain();

		write_steps(2'd2);
		random_run(450, 35, 57);
		write_steps(2'd0);
		random_run(450, 57, 35);
		write_steps(2'd3);
		random_run(350, 0, 0);
		write_steps(2'd1);
		random_run(60, 0, 0);

		if (err_cnt == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/fisr_pkg.sv
design/fisr_fmul.sv
design/fisr_fadd.sv
design/fast_inverse_square_root_core.sv
design/fisr_checker.sv
tb/tb.sv
